[src/sqps_pkg.sv]
// Shared constants, types and helpers for the square-wave phase sequencer.
package sqps_pkg;

  // Widths of the counters, samples and Q0.16 fractions.
  localparam int COUNT_WIDTH  = 24;
  localparam int SAMPLE_WIDTH = 16;
  localparam int FRAC_WIDTH   = 16;
  localparam int FRAC_HALF    = 32768;
  localparam int CFG_DATA_WIDTH = (COUNT_WIDTH > FRAC_WIDTH) ? COUNT_WIDTH : FRAC_WIDTH;
  localparam int CFG_IDX_WIDTH  = 3;
  localparam int PHASE_WIDTH    = 4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_WIDTH-1:0] REG_INITIAL_DELAY = 3'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_SETTLE_FIRST  = 3'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_TRAIL_FIRST   = 3'd2;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_SETTLE_SECOND = 3'd3;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_TRAIL_SECOND  = 3'd4;

  // Phase codes.
  localparam logic [PHASE_WIDTH-1:0] PH_DELAY    = 4'd0;
  localparam logic [PHASE_WIDTH-1:0] PH_EDGE0    = 4'd1;
  localparam logic [PHASE_WIDTH-1:0] PH_PERIOD   = 4'd2;
  localparam logic [PHASE_WIDTH-1:0] PH_SETTLE1  = 4'd3;
  localparam logic [PHASE_WIDTH-1:0] PH_COLLECT1 = 4'd4;
  localparam logic [PHASE_WIDTH-1:0] PH_EDGE1    = 4'd5;
  localparam logic [PHASE_WIDTH-1:0] PH_SETTLE2  = 4'd6;
  localparam logic [PHASE_WIDTH-1:0] PH_COLLECT2 = 4'd7;
  localparam logic [PHASE_WIDTH-1:0] PH_EDGE2    = 4'd8;

  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef logic [FRAC_WIDTH-1:0]  frac_t;
  // One more bit so that a full-scale fraction of 1.0 fits.
  typedef logic [FRAC_WIDTH:0]    frac_ext_t;

  // Configuration registers as seen by the sequencer.
  typedef struct packed {
    count_t initial_delay;
    frac_t  settle_first;
    frac_t  trail_first;
    frac_t  settle_second;
    frac_t  trail_second;
  } cfg_t;

  // One result transaction.
  typedef struct packed {
    logic [PHASE_WIDTH-1:0] handled_phase;
    logic                   phase_ended;
    count_t                 period_value;
  } result_t;

  // Saturating increment of a counter.
  function automatic count_t sat_inc(input count_t v);
    count_t res;
    res = (v == {COUNT_WIDTH{1'b1}}) ? v : v + count_t'(1);
    return res;
  endfunction

  // Window fraction: 1.0 - settle - trail, zero when that is not positive.
  function automatic frac_ext_t win_frac(input frac_t s, input frac_t t);
    frac_ext_t sum;
    frac_ext_t res;
    sum = {1'b0, s} + {1'b0, t};
    if (sum[FRAC_WIDTH]) begin
      res = '0;
    end else begin
      res = {1'b1, {FRAC_WIDTH{1'b0}}} - sum;
    end
    return res;
  endfunction

endpackage

[src/sqps_scale.sv]
// Scales a period by a Q0.16 fraction with round-half-up.
module sqps_scale (
  input  logic [sqps_pkg::FRAC_WIDTH:0]    frac_i,
  input  logic [sqps_pkg::COUNT_WIDTH-1:0] period_i,
  output logic [sqps_pkg::COUNT_WIDTH-1:0] len_o
);

  localparam int ProdWidth = sqps_pkg::FRAC_WIDTH + 1 + sqps_pkg::COUNT_WIDTH;

  logic [ProdWidth-1:0] prod;
  logic [ProdWidth:0]   rounded;

  // Single multiply, then add one half LSB and drop the fraction bits.
  assign prod    = ProdWidth'(frac_i) * ProdWidth'(period_i);
  assign rounded = {1'b0, prod} + (ProdWidth + 1)'(sqps_pkg::FRAC_HALF);
  assign len_o   = rounded[sqps_pkg::FRAC_WIDTH +: sqps_pkg::COUNT_WIDTH];

endmodule

[src/sqps_sequencer.sv]
// Phase state machine, counters and latched lengths of the sequencer.
module sqps_sequencer (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              accept_i,
  input  logic [sqps_pkg::SAMPLE_WIDTH-1:0] voltage_i,
  input  sqps_pkg::cfg_t                    cfg_i,
  output sqps_pkg::result_t                 result_o
);

  logic [sqps_pkg::PHASE_WIDTH-1:0]  phase_q, phase_d;
  logic [sqps_pkg::SAMPLE_WIDTH-1:0] last_level_q, last_level_d;
  sqps_pkg::count_t delay_count_q, delay_count_d;
  sqps_pkg::count_t period_count_q, period_count_d;
  sqps_pkg::count_t settle_count_q, settle_count_d;
  sqps_pkg::count_t window_count_q, window_count_d;
  sqps_pkg::count_t settle_len1_q, settle_len1_d;
  sqps_pkg::count_t settle_len2_q, settle_len2_d;
  sqps_pkg::count_t window_len1_q, window_len1_d;
  sqps_pkg::count_t window_len2_q, window_len2_d;

  sqps_pkg::count_t calc_settle1, calc_settle2, calc_window1, calc_window2;
  sqps_pkg::count_t delay_inc;
  logic             changed;

  // Four scalers run in parallel on the running period count.
  sqps_scale u_settle1 (
    .frac_i  ({1'b0, cfg_i.settle_first}),
    .period_i(period_count_q),
    .len_o   (calc_settle1)
  );

  sqps_scale u_settle2 (
    .frac_i  ({1'b0, cfg_i.settle_second}),
    .period_i(period_count_q),
    .len_o   (calc_settle2)
  );

  sqps_scale u_window1 (
    .frac_i  (sqps_pkg::win_frac(cfg_i.settle_first, cfg_i.trail_first)),
    .period_i(period_count_q),
    .len_o   (calc_window1)
  );

  sqps_scale u_window2 (
    .frac_i  (sqps_pkg::win_frac(cfg_i.settle_second, cfg_i.trail_second)),
    .period_i(period_count_q),
    .len_o   (calc_window2)
  );

  assign changed   = (voltage_i != last_level_q);
  assign delay_inc = sqps_pkg::sat_inc(delay_count_q);

  // Next-state logic for one sample.
  always_comb begin
    phase_d        = phase_q;
    last_level_d   = last_level_q;
    delay_count_d  = delay_count_q;
    period_count_d = period_count_q;
    settle_count_d = settle_count_q;
    window_count_d = window_count_q;
    settle_len1_d  = settle_len1_q;
    settle_len2_d  = settle_len2_q;
    window_len1_d  = window_len1_q;
    window_len2_d  = window_len2_q;
    result_o.handled_phase = phase_q;
    result_o.phase_ended   = 1'b0;
    result_o.period_value  = period_count_q;

    case (phase_q)
      sqps_pkg::PH_DELAY: begin
        delay_count_d = delay_inc;
        if (delay_inc > cfg_i.initial_delay) begin
          last_level_d         = voltage_i;
          phase_d              = sqps_pkg::PH_EDGE0;
          result_o.phase_ended = 1'b1;
        end
      end
      sqps_pkg::PH_EDGE0, sqps_pkg::PH_EDGE1, sqps_pkg::PH_EDGE2: begin
        if (changed) begin
          last_level_d         = voltage_i;
          result_o.phase_ended = 1'b1;
          if (phase_q == sqps_pkg::PH_EDGE0) begin
            phase_d = sqps_pkg::PH_PERIOD;
          end else if (phase_q == sqps_pkg::PH_EDGE1) begin
            phase_d = sqps_pkg::PH_SETTLE2;
          end else begin
            phase_d = sqps_pkg::PH_EDGE0;
          end
        end
      end
      sqps_pkg::PH_PERIOD: begin
        if (changed) begin
          last_level_d         = voltage_i;
          settle_len1_d        = calc_settle1;
          settle_len2_d        = calc_settle2;
          window_len1_d        = calc_window1;
          window_len2_d        = calc_window2;
          period_count_d       = '0;
          phase_d              = sqps_pkg::PH_SETTLE1;
          result_o.phase_ended = 1'b1;
        end else begin
          period_count_d = sqps_pkg::sat_inc(period_count_q);
        end
      end
      sqps_pkg::PH_SETTLE1, sqps_pkg::PH_SETTLE2: begin
        settle_count_d = sqps_pkg::sat_inc(settle_count_q);
        if (settle_count_q > ((phase_q == sqps_pkg::PH_SETTLE1) ?
                              settle_len1_q : settle_len2_q)) begin
          settle_count_d       = '0;
          phase_d              = phase_q + 4'd1;
          result_o.phase_ended = 1'b1;
        end
      end
      sqps_pkg::PH_COLLECT1, sqps_pkg::PH_COLLECT2: begin
        window_count_d = sqps_pkg::sat_inc(window_count_q);
        if (window_count_q >= ((phase_q == sqps_pkg::PH_COLLECT1) ?
                               window_len1_q : window_len2_q)) begin
          window_count_d       = '0;
          phase_d              = phase_q + 4'd1;
          result_o.phase_ended = 1'b1;
        end
      end
      default: begin
        result_o.handled_phase = sqps_pkg::PH_DELAY;
        phase_d                = sqps_pkg::PH_DELAY;
      end
    endcase
  end

  // State registers advance only on an accepted transaction.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= sqps_pkg::PH_DELAY;
      last_level_q   <= '0;
      delay_count_q  <= '0;
      period_count_q <= '0;
      settle_count_q <= '0;
      window_count_q <= '0;
      settle_len1_q  <= '0;
      settle_len2_q  <= '0;
      window_len1_q  <= '0;
      window_len2_q  <= '0;
    end else if (accept_i) begin
      phase_q        <= phase_d;
      last_level_q   <= last_level_d;
      delay_count_q  <= delay_count_d;
      period_count_q <= period_count_d;
      settle_count_q <= settle_count_d;
      window_count_q <= window_count_d;
      settle_len1_q  <= settle_len1_d;
      settle_len2_q  <= settle_len2_d;
      window_len1_q  <= window_len1_d;
      window_len2_q  <= window_len2_d;
    end
  end

  // The settle counter is only nonzero inside a settle phase.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (settle_count_q != '0) |->
      (phase_q == sqps_pkg::PH_SETTLE1 || phase_q == sqps_pkg::PH_SETTLE2))
    else $error("settle counter left nonzero outside settle phases");

  // The window counter is only nonzero inside a collect phase.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (window_count_q != '0) |->
      (phase_q == sqps_pkg::PH_COLLECT1 || phase_q == sqps_pkg::PH_COLLECT2))
    else $error("window counter left nonzero outside collect phases");

  // The period counter only runs during period measurement.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (period_count_q != '0) |-> (phase_q == sqps_pkg::PH_PERIOD))
    else $error("period counter nonzero outside period phase");

  // A level change in the period phase ends it and starts the first settle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && phase_q == sqps_pkg::PH_PERIOD && changed) |=>
      (phase_q == sqps_pkg::PH_SETTLE1 && period_count_q == '0))
    else $error("period end did not start first settle phase");

endmodule

[src/square_wave_phase_sequencer_core.sv]
// Top level of the square-wave phase sequencer: configuration and result register.
//
// Usage:
//   Input channel: voltage_i with in_valid_i / in_stall_o. A transaction is
//   taken at a rising edge with in_valid_i high and in_stall_o low.
//   Output channel: handled_phase_o, phase_ended_o, period_value_o with
//   out_valid_o / out_stall_i; each input sample yields exactly one result.
//   Configuration: cfg_we_i writes cfg_data_i into register cfg_index_i
//   (0 initial delay, 1..4 settle/trail fractions); write only while idle.
// The result is in the output register the cycle after the sample is taken.
// Throughput is one sample per cycle while the receiver does not stall, set by
// the single pass from the state registers through compares, counters and the
// four parallel 17x24 period scalers into the result register.
// Reset clears the phase to the initial delay, all counters and lengths, and
// all configuration registers to zero; no result is pending after reset.
// When the receiver stalls, the result register holds its contents and the
// input is stalled in the same cycle only while that register is full.
module square_wave_phase_sequencer_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [sqps_pkg::SAMPLE_WIDTH-1:0] voltage_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [sqps_pkg::PHASE_WIDTH-1:0]    handled_phase_o,
  output logic                                phase_ended_o,
  output logic [sqps_pkg::COUNT_WIDTH-1:0]    period_value_o,
  input  logic                                cfg_we_i,
  input  logic [sqps_pkg::CFG_IDX_WIDTH-1:0]  cfg_index_i,
  input  logic [sqps_pkg::CFG_DATA_WIDTH-1:0] cfg_data_i
);

  sqps_pkg::cfg_t    cfg_q;
  sqps_pkg::result_t result;
  sqps_pkg::result_t result_q;
  logic              out_valid_q;
  logic              accept;

  // Input is stalled only while an undelivered result is being held back.
  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;

  // Configuration register file.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        sqps_pkg::REG_INITIAL_DELAY: begin
          cfg_q.initial_delay <= cfg_data_i[sqps_pkg::COUNT_WIDTH-1:0];
        end
        sqps_pkg::REG_SETTLE_FIRST: begin
          cfg_q.settle_first <= cfg_data_i[sqps_pkg::FRAC_WIDTH-1:0];
        end
        sqps_pkg::REG_TRAIL_FIRST: begin
          cfg_q.trail_first <= cfg_data_i[sqps_pkg::FRAC_WIDTH-1:0];
        end
        sqps_pkg::REG_SETTLE_SECOND: begin
          cfg_q.settle_second <= cfg_data_i[sqps_pkg::FRAC_WIDTH-1:0];
        end
        sqps_pkg::REG_TRAIL_SECOND: begin
          cfg_q.trail_second <= cfg_data_i[sqps_pkg::FRAC_WIDTH-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  sqps_sequencer u_sequencer (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .voltage_i(voltage_i),
    .cfg_i    (cfg_q),
    .result_o (result)
  );

  // Result register: loads on every accepted transaction, empties when taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      result_q <= result;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign handled_phase_o = result_q.handled_phase;
  assign phase_ended_o   = result_q.phase_ended;
  assign period_value_o  = result_q.period_value;

endmodule

[dv/square_wave_phase_sequencer_core_tb.sv]
// Self-checking testbench for the square-wave phase sequencer core.
`timescale 1ns / 1ps

module square_wave_phase_sequencer_core_tb;

  typedef logic signed [sqps_pkg::SAMPLE_WIDTH-1:0] sample_t;

  localparam int      WATCHDOG_LIMIT = 2000;
  localparam int      PROD_WIDTH     = sqps_pkg::FRAC_WIDTH + sqps_pkg::COUNT_WIDTH + 2;
  localparam sample_t V_MIN          = 16'sh8000;
  localparam sample_t V_MAX          = 16'sh7FFF;

  logic                                      clk_i       = 1'b0;
  logic                                      rst_ni      = 1'b0;
  logic                                      in_valid_i  = 1'b0;
  logic                                      in_stall_o;
  sample_t                                   voltage_i   = '0;
  logic                                      out_valid_o;
  logic                                      out_stall_i = 1'b0;
  logic [sqps_pkg::PHASE_WIDTH-1:0]          handled_phase_o;
  logic                                      phase_ended_o;
  logic [sqps_pkg::COUNT_WIDTH-1:0]          period_value_o;
  logic                                      cfg_we_i    = 1'b0;
  logic [sqps_pkg::CFG_IDX_WIDTH-1:0]        cfg_index_i = sqps_pkg::REG_INITIAL_DELAY;
  logic [sqps_pkg::CFG_DATA_WIDTH-1:0]       cfg_data_i  = '0;

  // Results predicted for accepted samples, oldest first.
  sqps_pkg::result_t pending_results[$];
  int      mismatch_count = 0;
  int      idle_cycles    = 0;
  int      stall_left     = 0;
  // Set by a test to request one long receiver hold-off.
  int      receiver_hold_cycles = 0;
  // When set, neither side inserts random gaps.
  bit      no_gaps = 1'b0;

  // Predictor copy of the configuration registers.
  sqps_pkg::count_t delay_limit;
  sqps_pkg::frac_t  settle_frac1, trail_frac1, settle_frac2, trail_frac2;

  // Predictor copy of the sequencer state.
  logic [sqps_pkg::PHASE_WIDTH-1:0]  seq_phase;
  logic [sqps_pkg::SAMPLE_WIDTH-1:0] seq_level;
  sqps_pkg::count_t delay_cnt, period_cnt, settle_cnt, window_cnt;
  sqps_pkg::count_t settle_len1, settle_len2, window_len1, window_len2;

  square_wave_phase_sequencer_core u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .voltage_i      (voltage_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .handled_phase_o(handled_phase_o),
    .phase_ended_o  (phase_ended_o),
    .period_value_o (period_value_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Saturating counter increment.
  function automatic sqps_pkg::count_t count_up(input sqps_pkg::count_t v);
    return (&v) ? v : v + sqps_pkg::count_t'(1);
  endfunction

  // Scale a period by a Q0.16 fraction (up to 1.0), rounding half up.
  function automatic sqps_pkg::count_t scale_period(input logic [sqps_pkg::FRAC_WIDTH:0] frac,
                                                    input sqps_pkg::count_t period);
    logic [PROD_WIDTH-1:0] prod;
    prod = PROD_WIDTH'(frac);
    prod = prod * PROD_WIDTH'(period) + PROD_WIDTH'(sqps_pkg::FRAC_HALF);
    return prod[sqps_pkg::FRAC_WIDTH +: sqps_pkg::COUNT_WIDTH];
  endfunction

  // Collect window: what remains of the period after settle and trail, never below zero.
  function automatic sqps_pkg::count_t window_length(input sqps_pkg::frac_t settle,
                                                     input sqps_pkg::frac_t trail,
                                                     input sqps_pkg::count_t period);
    logic [sqps_pkg::FRAC_WIDTH:0] spent;
    logic [sqps_pkg::FRAC_WIDTH:0] remaining;
    spent = {1'b0, settle} + {1'b0, trail};
    if (spent[sqps_pkg::FRAC_WIDTH]) begin
      return '0;
    end
    remaining = {1'b1, {sqps_pkg::FRAC_WIDTH{1'b0}}} - spent;
    return scale_period(remaining, period);
  endfunction

  // Advance the predicted sequencer by one sample and return the expected result.
  function automatic sqps_pkg::result_t advance_sequencer(
    input logic [sqps_pkg::SAMPLE_WIDTH-1:0] v);
    sqps_pkg::result_t res;
    sqps_pkg::count_t  prior;
    logic              moved;
    moved             = (v != seq_level);
    res.handled_phase = seq_phase;
    res.phase_ended   = 1'b0;
    res.period_value  = period_cnt;
    case (seq_phase)
      sqps_pkg::PH_DELAY: begin
        delay_cnt = count_up(delay_cnt);
        if (delay_cnt > delay_limit) begin
          seq_level       = v;
          seq_phase       = sqps_pkg::PH_EDGE0;
          res.phase_ended = 1'b1;
        end
      end
      sqps_pkg::PH_EDGE0, sqps_pkg::PH_EDGE1, sqps_pkg::PH_EDGE2: begin
        if (moved) begin
          seq_level       = v;
          seq_phase       = (seq_phase == sqps_pkg::PH_EDGE0) ? sqps_pkg::PH_PERIOD :
                            (seq_phase == sqps_pkg::PH_EDGE1) ? sqps_pkg::PH_SETTLE2 :
                                                                sqps_pkg::PH_EDGE0;
          res.phase_ended = 1'b1;
        end
      end
      sqps_pkg::PH_PERIOD: begin
        if (moved) begin
          seq_level       = v;
          settle_len1     = scale_period({1'b0, settle_frac1}, period_cnt);
          settle_len2     = scale_period({1'b0, settle_frac2}, period_cnt);
          window_len1     = window_length(settle_frac1, trail_frac1, period_cnt);
          window_len2     = window_length(settle_frac2, trail_frac2, period_cnt);
          period_cnt      = '0;
          seq_phase       = sqps_pkg::PH_SETTLE1;
          res.phase_ended = 1'b1;
        end else begin
          period_cnt = count_up(period_cnt);
        end
      end
      sqps_pkg::PH_SETTLE1, sqps_pkg::PH_SETTLE2: begin
        prior      = settle_cnt;
        settle_cnt = count_up(settle_cnt);
        if (prior > ((seq_phase == sqps_pkg::PH_SETTLE1) ? settle_len1 : settle_len2)) begin
          settle_cnt      = '0;
          seq_phase       = seq_phase + 4'd1;
          res.phase_ended = 1'b1;
        end
      end
      sqps_pkg::PH_COLLECT1, sqps_pkg::PH_COLLECT2: begin
        prior      = window_cnt;
        window_cnt = count_up(window_cnt);
        if (prior >= ((seq_phase == sqps_pkg::PH_COLLECT1) ? window_len1 : window_len2)) begin
          window_cnt      = '0;
          seq_phase       = seq_phase + 4'd1;
          res.phase_ended = 1'b1;
        end
      end
      default: begin
        // Unused phase codes fall back to the delay phase.
        res.handled_phase = sqps_pkg::PH_DELAY;
        seq_phase         = sqps_pkg::PH_DELAY;
      end
    endcase
    return res;
  endfunction

  // Random sender gap: mostly none, some short, a few long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 55) begin
      return 0;
    end
    return (r < 90) ? $urandom_range(1, 3) : $urandom_range(8, 40);
  endfunction

  // Fraction register value, biased toward the extremes and small values.
  function automatic sqps_pkg::frac_t pick_frac();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return sqps_pkg::frac_t'($urandom_range(0, 2047));
      default: return sqps_pkg::frac_t'($urandom);
    endcase
  endfunction

  // Record every accepted input transaction in the predictor.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      pending_results.push_back(advance_sequencer(voltage_i));
    end
  end

  // Check each accepted result transaction and drive the receiver stall.
  always @(posedge clk_i) begin : result_checker
    sqps_pkg::result_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          $display("%0t: result with none expected, actual phase %0d ended %0d period %0d",
                   $time, handled_phase_o, phase_ended_o, period_value_o);
          mismatch_count++;
        end else begin
          want = pending_results.pop_front();
          if (handled_phase_o !== want.handled_phase) begin
            $display("%0t: handled_phase expected %0d actual %0d",
                     $time, want.handled_phase, handled_phase_o);
            mismatch_count++;
          end
          if (phase_ended_o !== want.phase_ended) begin
            $display("%0t: phase_ended expected %0d actual %0d",
                     $time, want.phase_ended, phase_ended_o);
            mismatch_count++;
          end
          if (period_value_o !== want.period_value) begin
            $display("%0t: period_value expected %0d actual %0d",
                     $time, want.period_value, period_value_o);
            mismatch_count++;
          end
        end
      end
      // A requested hold-off takes priority over random stalls.
      if (receiver_hold_cycles > 0) begin
        stall_left           = receiver_hold_cycles;
        receiver_hold_cycles = 0;
      end
      if (stall_left > 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else if (no_gaps || $urandom_range(0, 99) < 70) begin
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= 1'b1;
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
      end
    end
  end

  // Give up when no transaction moves on either channel for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // Offer one sample and return at the edge where it is accepted.
  task automatic send_sample(input sample_t v);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    voltage_i  <= v;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Stop sending and wait until every predicted result has been checked.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  // Write one configuration register; only called while the block is idle.
  task automatic write_reg(input logic [sqps_pkg::CFG_IDX_WIDTH-1:0] idx,
                           input logic [sqps_pkg::CFG_DATA_WIDTH-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    case (idx)
      sqps_pkg::REG_INITIAL_DELAY: delay_limit  = data[sqps_pkg::COUNT_WIDTH-1:0];
      sqps_pkg::REG_SETTLE_FIRST:  settle_frac1 = data[sqps_pkg::FRAC_WIDTH-1:0];
      sqps_pkg::REG_TRAIL_FIRST:   trail_frac1  = data[sqps_pkg::FRAC_WIDTH-1:0];
      sqps_pkg::REG_SETTLE_SECOND: settle_frac2 = data[sqps_pkg::FRAC_WIDTH-1:0];
      sqps_pkg::REG_TRAIL_SECOND:  trail_frac2  = data[sqps_pkg::FRAC_WIDTH-1:0];
      default: ;
    endcase
    cfg_we_i <= 1'b0;
  endtask

  // Fraction writes carry random upper bits, which the register must drop.
  task automatic write_fracs(input sqps_pkg::frac_t s1, input sqps_pkg::frac_t t1,
                             input sqps_pkg::frac_t s2, input sqps_pkg::frac_t t2);
    write_reg(sqps_pkg::REG_SETTLE_FIRST,  {8'($urandom), s1});
    write_reg(sqps_pkg::REG_TRAIL_FIRST,   {8'($urandom), t1});
    write_reg(sqps_pkg::REG_SETTLE_SECOND, {8'($urandom), s2});
    write_reg(sqps_pkg::REG_TRAIL_SECOND,  {8'($urandom), t2});
  endtask

  // Square wave with random levels and half period, occasional jitter and noise.
  task automatic send_square_wave(input int n_items, input int half_lo, input int half_hi);
    sample_t lvl_a;
    sample_t lvl_b;
    int half;
    int pos;
    bit upper;
    lvl_a = sample_t'($urandom);
    lvl_b = sample_t'($urandom);
    if (lvl_a == lvl_b) lvl_b = ~lvl_a;
    half  = $urandom_range(half_lo, half_hi);
    pos   = 0;
    upper = 1'b0;
    repeat (n_items) begin
      if ($urandom_range(0, 99) < 3) begin
        send_sample(sample_t'($urandom));
      end else begin
        send_sample(upper ? lvl_b : lvl_a);
      end
      pos++;
      if (pos >= half) begin
        pos   = 0;
        upper = !upper;
        if ($urandom_range(0, 7) == 0) half = $urandom_range(half_lo, half_hi);
      end
    end
  endtask

  // The delay phase: a saturated limit never ends it, a smaller one does.
  task automatic test_initial_delay();
    write_reg(sqps_pkg::REG_INITIAL_DELAY, {sqps_pkg::COUNT_WIDTH{1'b1}});
    send_sample(V_MAX);
    send_sample(V_MIN);
    send_sample('0);
    wait_drained();
    write_reg(sqps_pkg::REG_INITIAL_DELAY, 24'd2);
    send_sample(16'sd100);
    wait_drained();
  endtask

  // Extreme fractions, a zero-length period, then a full-scale square wave.
  task automatic test_directed_phases();
    write_fracs('0, '0, '1, '1);
    send_sample(16'sd100);
    send_sample(V_MIN);
    send_sample(V_MAX);
    for (int i = 0; i < 18; i++) begin
      send_sample(((i / 4) % 2) ? V_MIN : V_MAX);
    end
    wait_drained();
  endtask

  // The receiver holds off while samples keep coming, then the sender waits for drain.
  task automatic test_backpressure();
    write_fracs(sqps_pkg::frac_t'(16'h2000), sqps_pkg::frac_t'(16'h1000),
                sqps_pkg::frac_t'(16'h4000), sqps_pkg::frac_t'(16'h0800));
    no_gaps              = 1'b1;
    receiver_hold_cycles = 50;
    send_square_wave(30, 3, 5);
    wait_drained();
    send_square_wave(20, 2, 4);
    no_gaps = 1'b0;
    wait_drained();
  endtask

  // Randomized square waves over many register settings.
  task automatic test_random_waves();
    for (int ph = 0; ph < 12; ph++) begin
      if (ph == 0) begin
        write_fracs('0, '0, '0, '0);
      end else if (ph == 1) begin
        write_fracs('1, '1, '1, '1);
      end else begin
        write_fracs(pick_frac(), pick_frac(), pick_frac(), pick_frac());
      end
      if (ph % 4 == 3) begin
        send_square_wave(85, 20, 60);
      end else begin
        send_square_wave(85, 1, 10);
      end
      wait_drained();
    end
  endtask

  // Back-to-back traffic with no gaps or stalls on either side.
  task automatic test_streaming();
    write_fracs(pick_frac(), pick_frac(), pick_frac(), pick_frac());
    no_gaps = 1'b1;
    send_square_wave(120, 2, 6);
    no_gaps = 1'b0;
    wait_drained();
  endtask

  initial begin
    delay_limit  = '0;
    settle_frac1 = '0;
    trail_frac1  = '0;
    settle_frac2 = '0;
    trail_frac2  = '0;
    seq_phase    = sqps_pkg::PH_DELAY;
    seq_level    = '0;
    delay_cnt    = '0;
    period_cnt   = '0;
    settle_cnt   = '0;
    window_cnt   = '0;
    settle_len1  = '0;
    settle_len2  = '0;
    window_len1  = '0;
    window_len2  = '0;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_initial_delay();
    test_directed_phases();
    test_backpressure();
    test_random_waves();
    test_streaming();

    wait_drained();
    repeat (5) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[square_wave_phase_sequencer_core.f]
src/sqps_pkg.sv
src/sqps_scale.sv
src/sqps_sequencer.sv
src/square_wave_phase_sequencer_core.sv
dv/square_wave_phase_sequencer_core_tb.sv
